// ===== hdl/stereo_sine_tone_generator_top_defines.svh =====
`ifndef STEREO_SINE_TONE_GENERATOR_TOP_DEFINES_SVH
`define STEREO_SINE_TONE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define SSTG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define SSTG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sstg_pkg.sv =====
package sstg_pkg;

	localparam int FREQ_W  = 16;
	localparam int DUR_W   = 16;
	localparam int AMP_W   = 15;
	localparam int SMP_W   = 16;
	localparam int CNT_W   = 22;
	localparam int PHASE_W = 16;

	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = $clog2(Q_DEPTH);

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ARGS = 2'd1;
	localparam logic [1:0] ST_NO_TONE  = 2'd2;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd2000;
	localparam logic [SMP_W-1:0] MIDPOINT  = 16'h8000;
	localparam int               MS_PER_S  = 1000;

	typedef struct packed {
		logic              func;
		logic [FREQ_W-1:0] freq_hz;
		logic [DUR_W-1:0]  tone_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SMP_W-1:0] left_sample;
		logic [SMP_W-1:0] right_sample;
		logic             last;
	} rsp_t;

	// A classified item as it waits between the front and the back.
	typedef struct packed {
		logic               is_tick;
		logic               args_ok;
		logic [CNT_W-1:0]   count;
		logic [PHASE_W-1:0] step;
	} cmd_t;

endpackage

// ===== hdl/sstg_fifo.sv =====
module sstg_fifo import sstg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full    = (cnt_q == (PTR_W+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/sstg_front.sv =====
module sstg_front import sstg_pkg::*; #(
	parameter int FS_HZ = 44100
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic push,
	output cmd_t push_cmd,
	input  logic q_full
);

	localparam int PROD_W = $clog2(longint'(FS_HZ) * ((longint'(1) << DUR_W) - 1) + 1);
	localparam int CM_W   = PROD_W + CNT_W + 1;
	localparam longint unsigned CNT_RECIP = (64'd1 << PROD_W) / MS_PER_S;
	localparam int FQ_W   = $clog2((1 << FREQ_W) / FS_HZ + 2);
	localparam int FM_W   = FREQ_W + FQ_W;
	localparam longint unsigned FRQ_RECIP = (64'd1 << FREQ_W) / FS_HZ;

	localparam logic [PROD_W-1:0] SR_P = PROD_W'(FS_HZ);
	localparam logic [PROD_W-1:0] MS_P = PROD_W'(MS_PER_S);
	localparam logic [FREQ_W-1:0] SR_F = FREQ_W'(FS_HZ);

	logic              en;
	logic              v_s1, v_s2, v_s3;
	logic              tick_s1, tick_s2;
	logic              dur_nz_s1, dur_nz_s2;
	logic [FREQ_W-1:0] freq_s1, freq_s2;
	logic [PROD_W-1:0] prod_s1, prod_s2;
	logic [CNT_W-1:0]  cq_s2;
	logic [FQ_W-1:0]   fq_s2;
	logic [CM_W-1:0]   cnt_mul;
	logic [FM_W-1:0]   frq_mul;
	logic [PROD_W-1:0] cnt_rem;
	logic [CNT_W-1:0]  count;
	logic [FREQ_W-1:0] frq_rem;
	logic [FREQ_W-1:0] step;
	cmd_t              cmd_s3;

	assign en        = !v_s3 || !q_full;
	assign req_ready = en;
	assign push      = v_s3 && !q_full;
	assign push_cmd  = cmd_s3;

	// Both quotients come from a reciprocal multiply that is at most one short.
	assign cnt_mul = CM_W'(prod_s1) * CM_W'(CNT_RECIP);
	assign frq_mul = FM_W'(freq_s1) * FM_W'(FRQ_RECIP);

	assign cnt_rem = prod_s2 - PROD_W'(cq_s2) * MS_P;
	assign count   = cq_s2 + CNT_W'(cnt_rem >= MS_P);
	assign frq_rem = freq_s2 - FREQ_W'(fq_s2) * SR_F;
	assign step    = (frq_rem >= SR_F) ? frq_rem - SR_F : frq_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tick_s1   <= (req.func == FUNC_TICK);
			freq_s1   <= req.freq_hz;
			dur_nz_s1 <= (req.tone_ms != '0);
			prod_s1   <= SR_P * PROD_W'(req.tone_ms);

			tick_s2   <= tick_s1;
			freq_s2   <= freq_s1;
			dur_nz_s2 <= dur_nz_s1;
			prod_s2   <= prod_s1;
			cq_s2     <= cnt_mul[PROD_W +: CNT_W];
			fq_s2     <= frq_mul[FREQ_W +: FQ_W];

			cmd_s3.is_tick <= tick_s2;
			cmd_s3.args_ok <= (freq_s2 != '0) && dur_nz_s2 && (count != '0);
			cmd_s3.count   <= count;
			cmd_s3.step    <= step;
		end
	end

endmodule

// ===== hdl/sstg_back.sv =====
module sstg_back import sstg_pkg::*; #(
	parameter int FS_HZ           = 44100,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AMP_W-1:0] amplitude,
	input  logic             q_empty,
	input  cmd_t             cmd,
	output logic             pop,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int IW = $clog2(SINE_TABLE_SIZE);
	localparam int SH = $clog2(longint'(FS_HZ) * SINE_TABLE_SIZE);
	localparam int IM_W = PHASE_W + SH;
	localparam longint unsigned IDX_RECIP = (64'd1 << SH) / FS_HZ;
	localparam longint unsigned IDX_MULT  = IDX_RECIP * SINE_TABLE_SIZE;
	localparam logic [SH-1:0]      SR_N  = SH'(FS_HZ);
	localparam logic [SH-1:0]      TBL_S = SH'(SINE_TABLE_SIZE);
	localparam logic [PHASE_W-1:0] SR_PH = PHASE_W'(FS_HZ);

	localparam longint unsigned TBL_N       = SINE_TABLE_SIZE;
	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
	localparam longint unsigned Q30_PI      = 64'd3373259426;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	// Q1.15 sine of 2*pi*k/N: Taylor series to the 13th power in Q2.30.
	function automatic logic signed [SMP_W-1:0] sine_entry(input longint unsigned k);
		longint unsigned x, x2, t, d, s, mag;
		logic neg;
		x = (k * Q30_TWO_PI + TBL_N / 2) / TBL_N;
		neg = 1'b0;
		if (x >= Q30_PI) begin
			x = x - Q30_PI;
			neg = 1'b1;
		end
		if (x > Q30_HALF_PI) begin
			x = (x > Q30_PI) ? 64'd0 : Q30_PI - x;
		end
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		d = ((x2 * t) >> 30) / 64'd156;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		d = ((x2 * t) >> 30) / 64'd110;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		d = ((x2 * t) >> 30) / 64'd72;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		d = ((x2 * t) >> 30) / 64'd42;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		d = ((x2 * t) >> 30) / 64'd20;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		d = ((x2 * t) >> 30) / 64'd6;
		t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
		s = (x * t) >> 30;
		mag = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return neg ? -SMP_W'(mag) : SMP_W'(mag);
	endfunction

	logic signed [SMP_W-1:0] rom [SINE_TABLE_SIZE];

	for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_rom
		localparam logic signed [SMP_W-1:0] ENTRY = sine_entry(k);
		assign rom[k] = ENTRY;
	end

	logic               en;
	logic               active_q;
	logic [CNT_W-1:0]   left_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] step_q;
	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W-1:0] phase_nxt;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [1:0] status_s1, status_s2, status_s3, status_s4;
	logic snd_s1, snd_s2, snd_s3, snd_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [PHASE_W-1:0] ph_s1;
	logic [IM_W-1:0]    idx_mul;
	logic [IW-1:0]      qe_s2;
	logic [SH-1:0]      n_s2;
	logic [SH-1:0]      idx_rem;
	logic [IW-1:0]      idx_s3;
	logic signed [SMP_W-1:0]   sin_s4;
	logic signed [2*SMP_W-1:0] amp_prod;
	logic [SMP_W-1:0]   val;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign en        = !rsp_valid_q || rsp_ready;
	assign pop       = !q_empty && en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
	assign phase_nxt = (phase_sum >= {1'b0, SR_PH}) ? PHASE_W'(phase_sum - {1'b0, SR_PH})
		: PHASE_W'(phase_sum);

	// Table index is floor(phase * N / rate), estimated low by at most one.
	assign idx_mul = IM_W'(ph_s1) * IM_W'(IDX_MULT);
	assign idx_rem = n_s2 - SH'(qe_s2) * SR_N;

	assign amp_prod = $signed({1'b0, amplitude}) * sin_s4;
	assign val      = SMP_W'(amp_prod >>> 15) + MIDPOINT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			left_q      <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			rsp_valid_q <= v_s4;
			if (pop) begin
				if (!cmd.is_tick) begin
					if (cmd.args_ok) begin
						active_q <= 1'b1;
						left_q   <= cmd.count;
						phase_q  <= '0;
						step_q   <= cmd.step;
					end
				end else if (active_q) begin
					phase_q <= phase_nxt;
					left_q  <= left_q - 1'b1;
					if (left_q == CNT_W'(1)) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= phase_q;
			if (!cmd.is_tick) begin
				status_s1 <= cmd.args_ok ? ST_OK : ST_BAD_ARGS;
				snd_s1    <= 1'b0;
				last_s1   <= 1'b0;
			end else if (active_q) begin
				status_s1 <= ST_OK;
				snd_s1    <= 1'b1;
				last_s1   <= (left_q == CNT_W'(1));
			end else begin
				status_s1 <= ST_NO_TONE;
				snd_s1    <= 1'b0;
				last_s1   <= 1'b0;
			end

			status_s2 <= status_s1;
			snd_s2    <= snd_s1;
			last_s2   <= last_s1;
			qe_s2     <= idx_mul[SH +: IW];
			n_s2      <= SH'(ph_s1) * TBL_S;

			status_s3 <= status_s2;
			snd_s3    <= snd_s2;
			last_s3   <= last_s2;
			idx_s3    <= qe_s2 + IW'(idx_rem >= SR_N);

			status_s4 <= status_s3;
			snd_s4    <= snd_s3;
			last_s4   <= last_s3;
			sin_s4    <= rom[idx_s3];

			rsp_q.status       <= status_s4;
			rsp_q.left_sample  <= snd_s4 ? val : '0;
			rsp_q.right_sample <= snd_s4 ? val : '0;
			rsp_q.last         <= last_s4;
		end
	end

endmodule

// ===== hdl/stereo_sine_tone_generator_top.sv =====
// Stereo sine tone generator, direct digital synthesis.
// Requests arrive on req (valid/ready). A start request (func 0) carries a
// frequency and a duration; a tick request (func 1) asks for the next stereo
// pair. Every request yields exactly one response on rsp (valid/ready), in
// request order: a start gives ok or invalid arguments, a tick gives a sample
// pair with last on the final sample, or a no-tone status when idle.
// The amplitude register is written through cfg_we/cfg_wdata and takes
// effect on the next sample; the user must write it only while the block is
// idle, which the block itself does not enforce. A request passes three
// front stages, the first loading at the transfer edge, that compute the
// sample count and phase step, then one queue slot, then five back stages
// for the tone state, the table index, the sine table read and the amplitude
// multiply. One request per cycle is sustained when nothing stalls; the tone
// state update in the back's first stage is the loop.
// When the receiver stalls, the back pipeline holds its response and freezes,
// the four-entry queue absorbs the front's output, and req_ready drops once
// the queue is full and the last front stage holds a request.
// Reset clears the pipelines and queue, ends any tone and sets the amplitude
// to 2000.
module stereo_sine_tone_generator_top import sstg_pkg::*; #(
	parameter int FS_HZ           = 44100,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [AMP_W-1:0] cfg_wdata
);

	logic [AMP_W-1:0] amplitude_q;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	cmd_t             pop_cmd;
	logic             q_full;
	logic             q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMP_RESET;
		end else if (cfg_we) begin
			amplitude_q <= cfg_wdata;
		end
	end

	sstg_front #(
		.FS_HZ(FS_HZ)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	sstg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	sstg_back #(
		.FS_HZ          (FS_HZ),
		.SINE_TABLE_SIZE(SINE_TABLE_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.amplitude(amplitude_q),
		.q_empty  (q_empty),
		.cmd      (pop_cmd),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// ===== hdl/sstg_checker.sv =====
`include "stereo_sine_tone_generator_top_defines.svh"

module sstg_checker import sstg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled response must not move.
	`SSTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

	// A non-ok response carries no audio and no last mark.
	`SSTG_ASSERT_NOW(a_status_clean, rsp_valid && rsp.status != ST_OK, rsp.left_sample == '0 && rsp.right_sample == '0 && !rsp.last, "non-ok response carries sample data")

	`SSTG_ASSERT_NOW(a_stereo_equal, rsp_valid, rsp.left_sample == rsp.right_sample, "left and right channels differ")

endmodule

bind stereo_sine_tone_generator_top sstg_checker u_sstg_checker (.*);
